### hw/rtl/bplp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the button press / long-press event block.
// No dependencies; imported by every module of the block.
package bplp_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int BTN_W     = 2;
    localparam int SLOTS     = 4;

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd800;
    localparam logic [CFG_W-1:0] FORCE_QUIT_RESET = 16'd2000;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_QUIT = 2'd1;

    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_LONG    = 2'd2;
    localparam logic [1:0] KIND_READOUT = 2'd3;

    localparam logic [1:0] GEST_NONE  = 2'd0;
    localparam logic [1:0] GEST_VOLUP = 2'd1;
    localparam logic [1:0] GEST_VOLDN = 2'd2;
    localparam logic [1:0] GEST_QUIT  = 2'd3;

    localparam int BTN_QUIT  = 0;
    localparam int BTN_VOLUP = 1;
    localparam int BTN_VOLDN = 2;

    // what one button lane reports for the current poll
    typedef struct packed {
        logic              has_evt;
        logic [1:0]        kind;
        logic [TIME_W-1:0] hold;
        logic              fire_long;
        logic              quit_hit;
    } t_lane_res;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BTN_W-1:0]  button;
        logic [TIME_W-1:0] hold;
        logic [1:0]        gesture;
        logic              claimed;
    } t_slot;

endpackage

### hw/rtl/button_press_long_press_events.sv
`timescale 1ns / 1ps
// Button press / release / long-press event generator with system gestures.
// Depends on bplp_pkg, bplp_lane, bplp_merge.
// Input channel (i_in_valid / o_in_stall): one request per poll tick with
//   i_command = 0, the four active-low levels and the ms time; i_command = 1
//   reads out and clears the latched gesture (one result).
// Output channel (o_out_valid / i_out_stall): events in button order, one
//   per cycle unless stalled; o_last_of_run marks the final event of a
//   request. A poll that changes nothing gives no result.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
//   the long-press threshold, index 1 the force-quit threshold; other
//   indexes are ignored. Write only while idle.
// Timing: one lane per button evaluates a poll in the accept cycle; its events
//   are registered in a four-slot buffer and then in the output register. Events
//   drain at one per cycle while the output is not stalled; the next request is
//   taken in the cycle the last event moves out.
// Stall: the output register holds and the slot buffer keeps the rest;
//   o_in_stall stays high until the buffer drains. Reset (synchronous, active
//   low) clears button state, gestures, buffers and restores 800 / 2000 ms.
module button_press_long_press_events #(
    parameter int NUM_BUTTONS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [bplp_pkg::SLOTS-1:0]          i_button_levels,
    input  logic [bplp_pkg::TIME_W-1:0]         i_now_ms,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bplp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bplp_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_event_kind,
    output logic [bplp_pkg::BTN_W-1:0]          o_button_index,
    output logic [bplp_pkg::TIME_W-1:0]         o_hold_time,
    output logic [bplp_pkg::TIME_W-1:0]         o_event_time,
    output logic [1:0]                          o_gesture_code,
    output logic                                o_claimed,
    output logic                                o_last_of_run
);
    import bplp_pkg::*;

    // levels and result slots are sized for four buttons
    localparam int NB = (NUM_BUTTONS > SLOTS) ? SLOTS : NUM_BUTTONS;

    logic [CFG_W-1:0] r_long_ms;
    logic [CFG_W-1:0] r_quit_ms;
    logic             buf_free;
    logic             accept;
    logic             upd;
    t_lane_res        lane_res [SLOTS];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !buf_free;
    assign accept      = i_in_valid && buf_free;
    assign upd         = accept && (i_command == CMD_POLL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ms <= LONG_PRESS_RESET;
            r_quit_ms <= FORCE_QUIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LONG_PRESS: r_long_ms <= i_cfg_data;
                REG_FORCE_QUIT: r_quit_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_lane
        if (g < NB) begin : g_on
            bplp_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_upd     (upd),
                .i_down    (!i_button_levels[g]),
                .i_now     (i_now_ms),
                .i_long_ms (r_long_ms),
                .i_quit_ms (r_quit_ms),
                .o_res     (lane_res[g])
            );
        end else begin : g_off
            assign lane_res[g] = '0;
        end
    end

    bplp_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_command      (i_command),
        .i_now          (i_now_ms),
        .i_lane         (lane_res),
        .i_out_stall    (i_out_stall),
        .o_buf_free     (buf_free),
        .o_out_valid    (o_out_valid),
        .o_event_kind   (o_event_kind),
        .o_button_index (o_button_index),
        .o_hold_time    (o_hold_time),
        .o_event_time   (o_event_time),
        .o_gesture_code (o_gesture_code),
        .o_claimed      (o_claimed),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

### hw/rtl/bplp_lane.sv
`timescale 1ns / 1ps
// One button lane: debounced-level tracking, hold time and threshold checks.
// Depends on bplp_pkg.
module bplp_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_upd,
    input  logic                        i_down,
    input  logic [bplp_pkg::TIME_W-1:0] i_now,
    input  logic [bplp_pkg::CFG_W-1:0]  i_long_ms,
    input  logic [bplp_pkg::CFG_W-1:0]  i_quit_ms,
    output bplp_pkg::t_lane_res         o_res
);
    import bplp_pkg::*;

    logic              r_held;
    logic              r_long_done;
    logic [TIME_W-1:0] r_start;

    logic [TIME_W-1:0] held;
    logic              new_press;
    logic              rel;
    logic              stay;
    logic              fire;

    always_comb begin
        held      = i_now - r_start;
        new_press = i_down & ~r_held;
        rel       = ~i_down & r_held;
        stay      = i_down & r_held;
        fire      = stay & ~r_long_done & (held >= {{(TIME_W-CFG_W){1'b0}}, i_long_ms});

        o_res.has_evt   = new_press | rel | fire;
        o_res.kind      = new_press ? KIND_PRESS : (rel ? KIND_RELEASE : KIND_LONG);
        o_res.hold      = new_press ? '0 : held;
        o_res.fire_long = fire;
        o_res.quit_hit  = stay & (held >= {{(TIME_W-CFG_W){1'b0}}, i_quit_ms});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_long_done <= 1'b0;
        end else if (i_upd) begin
            if (new_press) begin
                r_held      <= 1'b1;
                r_long_done <= 1'b0;
            end else if (rel) begin
                r_held <= 1'b0;
            end else if (fire) begin
                r_long_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd && new_press) begin
            r_start <= i_now;
        end
    end

endmodule

### hw/rtl/bplp_merge.sv
`timescale 1ns / 1ps
// Merge stage: gesture chain over lanes, event slot buffer, output register.
// Depends on bplp_pkg; fed by the bplp_lane instances.
module bplp_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_command,
    input  logic [bplp_pkg::TIME_W-1:0] i_now,
    input  bplp_pkg::t_lane_res         i_lane [bplp_pkg::SLOTS],
    input  logic                        i_out_stall,
    output logic                        o_buf_free,
    output logic                        o_out_valid,
    output logic [1:0]                  o_event_kind,
    output logic [bplp_pkg::BTN_W-1:0]  o_button_index,
    output logic [bplp_pkg::TIME_W-1:0] o_hold_time,
    output logic [bplp_pkg::TIME_W-1:0] o_event_time,
    output logic [1:0]                  o_gesture_code,
    output logic                        o_claimed,
    output logic                        o_last_of_run
);
    import bplp_pkg::*;

    logic [1:0]        r_gest;
    logic              r_quit_done;
    logic [SLOTS-1:0]  r_mask;
    t_slot             r_slot [SLOTS];
    logic [TIME_W-1:0] r_time;

    logic              r_out_valid;
    t_slot             r_out;
    logic [TIME_W-1:0] r_out_time;
    logic              r_out_last;

    logic [1:0]        n_gest;
    logic              n_quit_done;
    logic              quit_fire;
    logic [SLOTS-1:0]  n_mask;
    t_slot             n_slot [SLOTS];
    logic [BTN_W-1:0]  idx;
    logic [SLOTS-1:0]  rest;
    logic              pop;
    logic              last;

    // gestures latch in button order; each long event shows the latch after its button
    always_comb begin
        n_gest      = r_gest;
        n_quit_done = r_quit_done;
        quit_fire   = i_lane[BTN_QUIT].quit_hit && !r_quit_done;
        for (int i = 0; i < SLOTS; i++) begin
            if (i == BTN_QUIT && quit_fire) begin
                n_gest = GEST_QUIT;
            end
            if (i == BTN_VOLUP && i_lane[i].fire_long) begin
                n_gest = GEST_VOLUP;
            end
            if (i == BTN_VOLDN && i_lane[i].fire_long) begin
                n_gest = GEST_VOLDN;
            end
            n_mask[i]         = i_lane[i].has_evt;
            n_slot[i].kind    = i_lane[i].kind;
            n_slot[i].button  = BTN_W'(i);
            n_slot[i].hold    = i_lane[i].hold;
            n_slot[i].gesture = i_lane[i].fire_long ? n_gest : GEST_NONE;
            n_slot[i].claimed = i_lane[i].fire_long && (n_gest != GEST_NONE);
        end
        if (i_lane[BTN_QUIT].has_evt && i_lane[BTN_QUIT].kind == KIND_PRESS) begin
            n_quit_done = 1'b0;
        end else if (quit_fire) begin
            n_quit_done = 1'b1;
        end
    end

    always_comb begin
        idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                idx = BTN_W'(k);
            end
        end
        rest       = r_mask & ~(SLOTS'(1) << idx);
        pop        = (r_mask != '0) && (!r_out_valid || !i_out_stall);
        last       = (rest == '0);
        o_buf_free = (r_mask == '0) || (pop && last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gest      <= GEST_NONE;
            r_quit_done <= 1'b0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                if (i_command == CMD_READ) begin
                    r_gest <= GEST_NONE;
                    r_mask <= SLOTS'(1);
                end else begin
                    r_gest      <= n_gest;
                    r_quit_done <= n_quit_done;
                    r_mask      <= n_mask;
                end
            end else if (pop) begin
                r_mask <= rest;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_time <= i_now;
            if (i_command == CMD_READ) begin
                r_slot[0].kind    <= KIND_READOUT;
                r_slot[0].button  <= '0;
                r_slot[0].hold    <= '0;
                r_slot[0].gesture <= r_gest;
                r_slot[0].claimed <= 1'b0;
            end else begin
                for (int i = 0; i < SLOTS; i++) begin
                    r_slot[i] <= n_slot[i];
                end
            end
        end
        if (pop) begin
            r_out      <= r_slot[idx];
            r_out_time <= r_time;
            r_out_last <= last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_out.kind;
    assign o_button_index = r_out.button;
    assign o_hold_time    = r_out.hold;
    assign o_event_time   = r_out_time;
    assign o_gesture_code = r_out.gesture;
    assign o_claimed      = r_out.claimed;
    assign o_last_of_run  = r_out_last;

`ifndef SYNTHESIS
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_command == CMD_READ) |=> (r_gest == GEST_NONE))
        else $error("gesture not cleared after readout");

    a_quit_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_command == CMD_POLL && quit_fire
         && !i_lane[BTN_VOLUP].fire_long && !i_lane[BTN_VOLDN].fire_long)
        |=> (r_gest == GEST_QUIT && r_quit_done))
        else $error("force quit not latched");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && last && !i_accept) |=> (r_mask == '0))
        else $error("slot buffer not empty after last request");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");
`endif

endmodule

### verif/button_press_long_press_events_test.sv
`timescale 1ns / 1ps
// Self-checking bench for button_press_long_press_events: queue-fed request driver,
// output monitor with an event predictor and a handshake watchdog. Needs bplp_pkg.
module button_press_long_press_events_test;
    import bplp_pkg::*;

    localparam int NB           = 4;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;

    // indexes with no register behind them, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [SLOTS-1:0]  levels;
        logic [TIME_W-1:0] now;
    } t_req;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BTN_W-1:0]  button;
        logic [TIME_W-1:0] hold;
        logic [TIME_W-1:0] stamp;
        logic [1:0]        gesture;
        logic              claimed;
        logic              last_flag;
    } t_evt;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_command;
    logic [SLOTS-1:0]     i_button_levels;
    logic [TIME_W-1:0]    i_now_ms;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [1:0]           o_event_kind;
    logic [BTN_W-1:0]     o_button_index;
    logic [TIME_W-1:0]    o_hold_time;
    logic [TIME_W-1:0]    o_event_time;
    logic [1:0]           o_gesture_code;
    logic                 o_claimed;
    logic                 o_last_of_run;

    button_press_long_press_events #(.NUM_BUTTONS(NB)) uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of the block state and registers
    logic              btn_down [NB];
    logic [TIME_W-1:0] btn_start [NB];
    logic              btn_long_done [NB];
    logic              quit_done;
    logic [1:0]        gesture_state;
    logic [CFG_W-1:0]  long_ms;
    logic [CFG_W-1:0]  quit_ms;

    t_req pending_requests [$];
    t_evt expected_events [$];

    logic              in_taken;
    int                idle_cycles;
    int                send_idle_pct;
    int                recv_idle_pct;
    logic [TIME_W-1:0] clock_ms;
    logic [SLOTS-1:0]  cur_levels;

    int errors;
    int accepted_reqs;
    int readouts;
    int long_events;
    int checked_events;
    int settings;

    function automatic t_evt make_evt(input logic [1:0] kind, input int button,
                                      input logic [TIME_W-1:0] hold,
                                      input logic [TIME_W-1:0] stamp,
                                      input logic [1:0] gesture, input logic claimed);
        t_evt e;
        e.kind      = kind;
        e.button    = BTN_W'(button);
        e.hold      = hold;
        e.stamp     = stamp;
        e.gesture   = gesture;
        e.claimed   = claimed;
        e.last_flag = 1'b0;
        return e;
    endfunction

    task automatic predict_events(input t_req r);
        t_evt              run [$];
        t_evt              e;
        logic              down;
        logic              fire;
        logic [TIME_W-1:0] held;
        if (r.cmd == CMD_READ) begin
            e = make_evt(KIND_READOUT, 0, '0, r.now, gesture_state, 1'b0);
            e.last_flag = 1'b1;
            gesture_state = GEST_NONE;
            readouts++;
            run.push_back(e);
        end else begin
            for (int i = 0; i < NB; i++) begin
                down = !r.levels[i];
                if (down && !btn_down[i]) begin
                    btn_down[i]      = 1'b1;
                    btn_start[i]     = r.now;
                    btn_long_done[i] = 1'b0;
                    if (i == BTN_QUIT) quit_done = 1'b0;
                    run.push_back(make_evt(KIND_PRESS, i, '0, r.now, GEST_NONE, 1'b0));
                end else if (!down && btn_down[i]) begin
                    btn_down[i] = 1'b0;
                    run.push_back(make_evt(KIND_RELEASE, i, r.now - btn_start[i], r.now,
                                           GEST_NONE, 1'b0));
                end else if (down) begin
                    held = r.now - btn_start[i];
                    fire = !btn_long_done[i] && (held >= long_ms);
                    if (fire) begin
                        btn_long_done[i] = 1'b1;
                        if (i == BTN_VOLUP) gesture_state = GEST_VOLUP;
                        else if (i == BTN_VOLDN) gesture_state = GEST_VOLDN;
                    end
                    // force quit is checked on every held tick, not only at the long event
                    if (i == BTN_QUIT && !quit_done && held >= quit_ms) begin
                        quit_done     = 1'b1;
                        gesture_state = GEST_QUIT;
                    end
                    if (fire) begin
                        long_events++;
                        run.push_back(make_evt(KIND_LONG, i, held, r.now, gesture_state,
                                               gesture_state != GEST_NONE));
                    end
                end
            end
            if (run.size() > 0) run[run.size()-1].last_flag = 1'b1;
        end
        foreach (run[k]) expected_events.push_back(run[k]);
    endtask

    task automatic compare_event(input t_evt got);
        t_evt want;
        if (expected_events.size() == 0) begin
            $error("unexpected event: kind %0d button %0d time %0h",
                   got.kind, got.button, got.stamp);
            errors++;
        end else begin
            want = expected_events.pop_front();
            checked_events++;
            if (got.kind !== want.kind) begin
                $error("event_kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.button !== want.button) begin
                $error("button_index: expected %0d, got %0d", want.button, got.button);
                errors++;
            end
            if (got.hold !== want.hold) begin
                $error("hold_time: expected %0h, got %0h", want.hold, got.hold);
                errors++;
            end
            if (got.stamp !== want.stamp) begin
                $error("event_time: expected %0h, got %0h", want.stamp, got.stamp);
                errors++;
            end
            if (got.gesture !== want.gesture) begin
                $error("gesture_code: expected %0d, got %0d", want.gesture, got.gesture);
                errors++;
            end
            if (got.claimed !== want.claimed) begin
                $error("claimed: expected %0d, got %0d", want.claimed, got.claimed);
                errors++;
            end
            if (got.last_flag !== want.last_flag) begin
                $error("last_of_run: expected %0d, got %0d", want.last_flag, got.last_flag);
                errors++;
            end
        end
    endtask

    // request driver and receiver stall, both change on the falling edge
    always @(negedge i_clk) begin : driver
        t_req r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                r = pending_requests.pop_front();
                i_in_valid      <= 1'b1;
                i_command       <= r.cmd;
                i_button_levels <= r.levels;
                i_now_ms        <= r.now;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_evt got;
        if (!i_rst_n) begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                got.kind      = o_event_kind;
                got.button    = o_button_index;
                got.hold      = o_hold_time;
                got.stamp     = o_event_time;
                got.gesture   = o_gesture_code;
                got.claimed   = o_claimed;
                got.last_flag = o_last_of_run;
                compare_event(got);
            end
            if (i_in_valid && !o_in_stall) begin
                predict_events({i_command, i_button_levels, i_now_ms});
                accepted_reqs++;
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_LONG_PRESS) long_ms = data;
        else if (idx == REG_FORCE_QUIT) quit_ms = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [CFG_W-1:0] long_val,
                                  input logic [CFG_W-1:0] quit_val);
        write_reg(REG_LONG_PRESS, long_val);
        write_reg(REG_FORCE_QUIT, quit_val);
        settings++;
    endtask

    task automatic push_req(input logic cmd, input logic [SLOTS-1:0] levels,
                            input logic [TIME_W-1:0] now);
        t_req r;
        r.cmd    = cmd;
        r.levels = levels;
        r.now    = now;
        pending_requests.push_back(r);
    endtask

    // mostly coherent press/hold/release traffic on a running clock, some noise
    task automatic fill_random(input int count);
        int               span;
        int               pick;
        logic [SLOTS-1:0] lv;
        @(posedge i_clk);
        span = ((long_ms > quit_ms) ? long_ms : quit_ms) / 4 + 1;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                clock_ms += $urandom_range(0, span);
                push_req(CMD_READ, SLOTS'($urandom), clock_ms);
            end else if (pick < 14) begin
                lv = SLOTS'($urandom);
                cur_levels = lv;
                push_req(CMD_POLL, lv, $urandom);
            end else begin
                clock_ms += $urandom_range(0, span);
                for (int b = 0; b < NB; b++)
                    if ($urandom_range(0, 99) < 12) cur_levels[b] = ~cur_levels[b];
                push_req(CMD_POLL, cur_levels, clock_ms);
            end
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || expected_events.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin : sequencer
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_command       = CMD_POLL;
        i_button_levels = '1;
        i_now_ms        = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_LONG_PRESS;
        i_cfg_data      = '0;
        i_out_stall     = 1'b0;
        for (int i = 0; i < NB; i++) begin
            btn_down[i]      = 1'b0;
            btn_start[i]     = '0;
            btn_long_done[i] = 1'b0;
        end
        quit_done      = 1'b0;
        gesture_state  = GEST_NONE;
        long_ms        = LONG_PRESS_RESET;
        quit_ms        = FORCE_QUIT_RESET;
        errors         = 0;
        accepted_reqs  = 0;
        readouts       = 0;
        long_events    = 0;
        checked_events = 0;
        settings       = 1;
        send_idle_pct  = 26;
        recv_idle_pct  = 48;
        cur_levels     = '1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset thresholds 800 / 2000
        @(posedge i_clk);
        push_req(CMD_READ, 4'h0, 32'd5);          // nothing latched yet
        push_req(CMD_POLL, 4'hF, 32'd10);         // no events
        push_req(CMD_POLL, 4'h0, 32'd100);        // four presses
        push_req(CMD_POLL, 4'h0, 32'd500);
        push_req(CMD_POLL, 4'h0, 32'd900);        // four long events, volume gestures claim
        push_req(CMD_READ, 4'hF, 32'd950);
        push_req(CMD_POLL, 4'h0, 32'd2100);       // force quit after the long event, silent
        push_req(CMD_READ, 4'h5, 32'd2150);
        push_req(CMD_POLL, 4'hF, 32'd2200);       // four releases
        push_req(CMD_POLL, 4'hE, 32'd3000);
        push_req(CMD_POLL, 4'hE, 32'd5000);       // both thresholds on one tick
        push_req(CMD_POLL, 4'hF, 32'd5001);
        push_req(CMD_READ, 4'hA, 32'd5002);
        push_req(CMD_POLL, 4'h7, 32'hFFFF_FF00);  // hold across time wrap
        push_req(CMD_POLL, 4'h7, 32'h0000_0300);
        push_req(CMD_POLL, 4'hF, 32'h0000_0400);
        push_req(CMD_POLL, 4'h0, 32'hFFFF_FFFF);
        push_req(CMD_POLL, 4'hF, 32'hFFFF_FFFF);  // zero hold
        clock_ms = 32'd10000;
        fill_random(56);
        settle();

        set_thresholds(16'd1, 16'd1);
        write_reg(REG_SPARE_2, CFG_W'($urandom));
        write_reg(REG_SPARE_3, 16'hFFFF);
        fill_random(62);
        settle();

        send_idle_pct = 48;
        recv_idle_pct = 26;
        set_thresholds(16'hFFFF, 16'hFFFF);
        clock_ms = 32'hFFFF_0000;
        fill_random(62);
        settle();

        set_thresholds(16'd0, 16'd0);
        fill_random(62);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_thresholds(16'd300, 16'd100);
        fill_random(62);
        settle();

        set_thresholds(16'd50, 16'd120);
        fill_random(62);
        settle();

        $display("run: %0d requests (%0d gesture readouts), %0d events checked",
                 accepted_reqs, readouts, checked_events);
        $display("     %0d long presses, %0d threshold settings, %0d mismatches",
                 long_events, settings, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bplp_pkg.sv
hw/rtl/bplp_lane.sv
hw/rtl/bplp_merge.sv
hw/rtl/button_press_long_press_events.sv
verif/button_press_long_press_events_test.sv
